### hw/rtl/qrot_pkg.sv
package qrot_pkg;

  typedef logic signed [31:0] comp_t;   // one quaternion component
  typedef logic signed [63:0] prod_t;   // full product of two components
  typedef logic signed [65:0] sum_t;    // exact sum of four signed products
  typedef logic [1:0]         idx_t;    // component index w, x, y, z

  localparam int NUM_COMP   = 4;
  localparam int NUM_STAGES = 6;

  // direction command
  localparam logic CMD_ROTATE   = 1'b0;  // q * v * conj(q)
  localparam logic CMD_DEROTATE = 1'b1;  // conj(q) * v * q

  localparam comp_t COMP_MAX = 32'sh7fff_ffff;
  localparam comp_t COMP_MIN = 32'sh8000_0000;
  localparam sum_t  SUM_MAX  = 66'sh0_7fff_ffff;
  localparam sum_t  SUM_MIN  = -66'sh0_8000_0000;

  // hamilton product: out[c] = sum over t of +/- a[t] * b[c ^ t]
  // bit t set means the term enters with a minus sign
  localparam logic [3:0] TERM_NEG [NUM_COMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  function automatic idx_t term_b(idx_t c, idx_t t);
    return c ^ t;
  endfunction

  // sign of one term, with conjugation of either operand folded in
  function automatic logic term_neg(idx_t c, idx_t t, logic conj_a, logic conj_b);
    logic neg;
    neg = TERM_NEG[c][t];
    if (conj_a && (t != '0)) neg = !neg;
    if (conj_b && (term_b(c, t) != '0)) neg = !neg;
    return neg;
  endfunction

endpackage

### hw/rtl/qrot_in_if.sv
interface qrot_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] rot_w;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic signed [31:0] vec_w;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (
    output valid, command, rot_w, rot_x, rot_y, rot_z, vec_w, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, command, rot_w, rot_x, rot_y, rot_z, vec_w, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

### hw/rtl/qrot_out_if.sv
interface qrot_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_w;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               overflow;

  modport source (
    output valid, out_w, out_x, out_y, out_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_w, out_x, out_y, out_z, overflow,
    output ready
  );
endinterface

### hw/rtl/quaternion_rotate_unit.sv
// channel   dir   payload                                   transfer when
// operand   in    command, rot_w..rot_z, vec_w..vec_z       valid & ready
// result    out   out_w..out_z, overflow                    valid & ready
//
// six register stages: multiply, add, shift/saturate, then the same again
// for the second hamilton product; one transfer per cycle while the result is not stalled
// each multiply stage has 16 parallel 32x32 multipliers
// rst (synchronous) clears only the stage valid bits
// each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and a stalled result blocks the input only once all six
// stages are full
module quaternion_rotate_unit #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  qrot_in_if.sink    operand,
  qrot_out_if.source result
);
  import qrot_pkg::*;

  // truncate toward minus infinity, then clamp to 32 bits; msb flags clamp
  function automatic logic [32:0] shift_sat(sum_t s);
    sum_t sh;
    sh = s >>> FRAC_BITS;
    if (sh > SUM_MAX) return {1'b1, COMP_MAX};
    if (sh < SUM_MIN) return {1'b1, COMP_MIN};
    return {1'b0, sh[31:0]};
  endfunction

  // stage valid bits and per-stage load enables
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  comp_t in_rot [NUM_COMP];
  comp_t in_vec [NUM_COMP];

  // stage 1: first product partial terms
  prod_t      m1_prod [NUM_COMP][NUM_COMP];
  logic [3:0] m1_neg  [NUM_COMP];
  comp_t      m1_rot  [NUM_COMP];
  logic       m1_cmd;

  // stage 2: first product sums
  sum_t  a1_sum [NUM_COMP];
  comp_t a1_rot [NUM_COMP];
  logic  a1_cmd;

  // stage 3: intermediate quaternion, truncated and saturated
  comp_t s1_tmp [NUM_COMP];
  comp_t s1_rot [NUM_COMP];
  logic  s1_cmd;
  logic  s1_ovf;

  // stage 4: second product partial terms
  prod_t      m2_prod [NUM_COMP][NUM_COMP];
  logic [3:0] m2_neg  [NUM_COMP];
  logic       m2_ovf;

  // stage 5: second product sums
  sum_t a2_sum [NUM_COMP];
  logic a2_ovf;

  // stage 6: output register
  comp_t r_out [NUM_COMP];
  logic  r_ovf;

  // combinational results feeding each register
  sum_t        a1_sum_next [NUM_COMP];
  sum_t        a2_sum_next [NUM_COMP];
  logic [32:0] s1_sat      [NUM_COMP];
  logic [32:0] r_sat       [NUM_COMP];

  assign in_rot = '{operand.rot_w, operand.rot_x, operand.rot_y, operand.rot_z};
  assign in_vec = '{operand.vec_w, operand.vec_x, operand.vec_y, operand.vec_z};

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || result.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign operand.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = NUM_STAGES - 1; k > 0; k--) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
      if (en[0]) vld[0] <= operand.valid;
    end
  end

  // first product: q * v on rotate, conj(q) * v on derotate
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        for (int t = 0; t < NUM_COMP; t++) begin
          m1_prod[c][t] <= prod_t'(in_rot[t]) * prod_t'(in_vec[term_b(idx_t'(c), idx_t'(t))]);
          m1_neg[c][t]  <= term_neg(idx_t'(c), idx_t'(t), operand.command == CMD_DEROTATE,
                                    1'b0);
        end
      end
      m1_rot <= in_rot;
      m1_cmd <= operand.command;
    end
  end

  // exact signed sum of the four terms of each component
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      a1_sum_next[c] = '0;
      a2_sum_next[c] = '0;
      for (int t = 0; t < NUM_COMP; t++) begin
        if (m1_neg[c][t]) a1_sum_next[c] = a1_sum_next[c] - sum_t'(m1_prod[c][t]);
        else              a1_sum_next[c] = a1_sum_next[c] + sum_t'(m1_prod[c][t]);
        if (m2_neg[c][t]) a2_sum_next[c] = a2_sum_next[c] - sum_t'(m2_prod[c][t]);
        else              a2_sum_next[c] = a2_sum_next[c] + sum_t'(m2_prod[c][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a1_sum <= a1_sum_next;
      a1_rot <= m1_rot;
      a1_cmd <= m1_cmd;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      s1_sat[c] = shift_sat(a1_sum[c]);
      r_sat[c]  = shift_sat(a2_sum[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        s1_tmp[c] <= s1_sat[c][31:0];
      end
      s1_ovf <= s1_sat[0][32] | s1_sat[1][32] | s1_sat[2][32] | s1_sat[3][32];
      s1_rot <= a1_rot;
      s1_cmd <= a1_cmd;
    end
  end

  // second product: tmp * conj(q) on rotate, tmp * q on derotate
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        for (int t = 0; t < NUM_COMP; t++) begin
          m2_prod[c][t] <= prod_t'(s1_tmp[t]) * prod_t'(s1_rot[term_b(idx_t'(c), idx_t'(t))]);
          m2_neg[c][t]  <= term_neg(idx_t'(c), idx_t'(t), 1'b0, s1_cmd == CMD_ROTATE);
        end
      end
      m2_ovf <= s1_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a2_sum <= a2_sum_next;
      a2_ovf <= m2_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        r_out[c] <= r_sat[c][31:0];
      end
      r_ovf <= a2_ovf | r_sat[0][32] | r_sat[1][32] | r_sat[2][32] | r_sat[3][32];
    end
  end

  assign result.valid    = vld[NUM_STAGES-1];
  assign result.out_w    = r_out[0];
  assign result.out_x    = r_out[1];
  assign result.out_y    = r_out[2];
  assign result.out_z    = r_out[3];
  assign result.overflow = r_ovf;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // an accepted transfer always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (operand.valid && operand.ready) |=> vld[0])
    else $error("accepted operand lost at first stage");

  // a full pipeline behind a stalled result takes nothing new
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !result.ready) |-> !operand.ready)
    else $error("operand accepted into full stalled pipeline");

  // results only come from the stage before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld[NUM_STAGES-2]))
    else $error("result appeared without a preceding item");

endmodule
